// File: rtl/fstk_pkg.sv
// Shared types and constants for the frequency stack.
// No dependencies.
package fstk_pkg;

   localparam int unsigned DefCapacity  = 64;
   localparam int unsigned DefValueBits = 8;
   localparam int unsigned DefSeqBits   = 32;

   typedef enum logic [1:0] {
      ST_PUSHED = 2'd0,
      ST_POPPED = 2'd1,
      ST_EMPTY  = 2'd2,
      ST_FULL   = 2'd3
   } status_type;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_PUSH_CNT,
      S_PUSH_WR,
      S_SCAN,
      S_SCAN_LAST,
      S_POP_RD,
      S_POP_WR,
      S_CLEAR,
      S_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic cnt_read;
      logic push_write;
      logic scan_start;
      logic scan_step;
      logic last_read;
      logic pop_write;
      logic clear_step;
      logic set_done;
   } cmd_type;

   typedef struct packed {
      logic is_pop;
      logic empty;
      logic full;
      logic scan_end;
      logic clear_end;
   } stat_type;

endpackage

// File: rtl/fstk_ctrl.sv
// Controller state machine for the frequency stack.
// Depends on fstk_pkg.
module fstk_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               taken,
   input  fstk_pkg::stat_type stat,
   output fstk_pkg::cmd_type  cmd,
   output logic               idle,
   output logic               out_valid
);
   import fstk_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_CLEAR;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR:     if (stat.clear_end) state_in = S_IDLE;
         S_IDLE: begin
            if (start) begin
               if (!stat.is_pop) state_in = stat.full ? S_DONE : S_PUSH_CNT;
               else              state_in = stat.empty ? S_DONE : S_SCAN;
            end
         end
         S_PUSH_CNT:  state_in = S_PUSH_WR;
         S_PUSH_WR:   state_in = S_DONE;
         S_SCAN:      if (stat.scan_end) state_in = S_SCAN_LAST;
         S_SCAN_LAST: state_in = S_POP_RD;
         S_POP_RD:    state_in = S_POP_WR;
         S_POP_WR:    state_in = S_DONE;
         S_DONE:      if (taken) state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      idle = 1'b0;
      out_valid = 1'b0;
      unique case (state_ff)
         S_CLEAR:     cmd.clear_step = 1'b1;
         S_IDLE: begin
            idle = 1'b1;
            cmd.load = start;
            cmd.scan_start = start;
            cmd.set_done = start;
         end
         S_PUSH_CNT:  cmd.cnt_read = 1'b1;
         S_PUSH_WR:   cmd.push_write = 1'b1;
         S_SCAN:      cmd.scan_step = 1'b1;
         S_SCAN_LAST: cmd.scan_step = 1'b1;
         S_POP_RD:    cmd.last_read = 1'b1;
         S_POP_WR:    cmd.pop_write = 1'b1;
         S_DONE:      out_valid = 1'b1;
         default:     idle = 1'b0;
      endcase
   end
endmodule

// File: rtl/fstk_dp.sv
// Datapath for the frequency stack: entry memory, count memory, scan unit.
// Depends on fstk_pkg.
module fstk_dp #(
   parameter int unsigned CAPACITY   = fstk_pkg::DefCapacity,
   parameter int unsigned VALUE_BITS = fstk_pkg::DefValueBits,
   parameter int unsigned SEQ_BITS   = fstk_pkg::DefSeqBits
) (
   input  logic                   clock,
   input  logic                   reset,
   input  fstk_pkg::cmd_type      cmd,
   input  logic                   in_op,
   input  logic [VALUE_BITS-1:0]  in_value,
   output fstk_pkg::stat_type     stat,
   output logic [VALUE_BITS-1:0]  popped_value,
   output fstk_pkg::status_type   status
);
   import fstk_pkg::*;

   localparam int unsigned AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int unsigned TW    = $clog2(CAPACITY + 1);
   localparam int unsigned CW    = TW;
   localparam int unsigned SPAN  = 1 << VALUE_BITS;
   localparam int unsigned EW    = CW + VALUE_BITS + SEQ_BITS;

   typedef struct packed {
      logic [CW-1:0]         count;
      logic [VALUE_BITS-1:0] value;
      logic [SEQ_BITS-1:0]   seq;
   } entry_type;

   entry_type             entry_mem [CAPACITY];
   logic [CW-1:0]         count_mem [SPAN];

   logic [TW-1:0]         total_ff;
   logic [SEQ_BITS-1:0]   seq_ff;
   logic                  op_ff;
   logic [VALUE_BITS-1:0] val_ff;
   logic [VALUE_BITS-1:0] popped_ff;
   status_type            status_ff;
   logic [VALUE_BITS-1:0] clr_ff;
   logic                  clr_done_ff;

   logic [TW-1:0]         scan_ff;
   logic                  scan_v_ff;
   entry_type             rd_ff;
   logic [AW-1:0]         rd_idx_ff;
   entry_type             best_ff;
   logic [AW-1:0]         best_idx_ff;
   logic                  best_v_ff;
   logic [CW-1:0]         cnt_rd_ff;

   logic [AW-1:0]         rd_addr;
   logic [TW-1:0]         last_idx;
   logic                  better;

   assign last_idx = total_ff - TW'(1);
   assign rd_addr  = cmd.last_read ? last_idx[AW-1:0] : scan_ff[AW-1:0];

   always_ff @(posedge clock) begin
      rd_ff <= entry_mem[rd_addr];
      rd_idx_ff <= rd_addr;
   end

   assign better = !best_v_ff || (rd_ff.count > best_ff.count) ||
                   ((rd_ff.count == best_ff.count) && (rd_ff.seq > best_ff.seq));

   logic [VALUE_BITS-1:0] cnt_addr;
   logic [CW-1:0]         cnt_cur;
   assign cnt_addr = cmd.cnt_read ? val_ff : best_ff.value;
   always_ff @(posedge clock) cnt_rd_ff <= count_mem[cnt_addr];
   assign cnt_cur = cnt_rd_ff;

   always_ff @(posedge clock) begin
      if (cmd.clear_step)
         count_mem[clr_ff] <= '0;
      else if (cmd.push_write)
         count_mem[val_ff] <= cnt_cur + CW'(1);
      else if (cmd.pop_write && cnt_cur != '0)
         count_mem[best_ff.value] <= cnt_cur - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (cmd.push_write)
         entry_mem[total_ff[AW-1:0]] <= '{count: cnt_cur + CW'(1), value: val_ff,
                                         seq: seq_ff};
      else if (cmd.pop_write && (TW'(best_idx_ff) != last_idx))
         entry_mem[best_idx_ff] <= rd_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= in_op;
         val_ff <= in_value;
      end
      if (cmd.scan_start) begin
         scan_ff   <= '0;
         scan_v_ff <= 1'b0;
         best_v_ff <= 1'b0;
      end else if (cmd.scan_step) begin
         scan_ff   <= scan_ff + TW'(1);
         scan_v_ff <= 1'b1;
         if (scan_v_ff && better) begin
            best_ff     <= rd_ff;
            best_idx_ff <= rd_idx_ff;
            best_v_ff   <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff    <= '0;
         seq_ff      <= '0;
         clr_ff      <= '0;
         clr_done_ff <= 1'b0;
         popped_ff   <= '0;
         status_ff   <= ST_PUSHED;
      end else begin
         if (cmd.clear_step) begin
            clr_ff <= clr_ff + VALUE_BITS'(1);
            if (clr_ff == '1) clr_done_ff <= 1'b1;
         end
         if (cmd.set_done) begin
            popped_ff <= '0;
            if (in_op == OP_PUSH)
               status_ff <= (total_ff >= TW'(CAPACITY)) ? ST_FULL : ST_PUSHED;
            else
               status_ff <= (total_ff == '0) ? ST_EMPTY : ST_POPPED;
         end
         if (cmd.push_write) begin
            total_ff <= total_ff + TW'(1);
            seq_ff   <= seq_ff + SEQ_BITS'(1);
         end
         if (cmd.pop_write) begin
            total_ff  <= last_idx;
            popped_ff <= best_ff.value;
            if (last_idx == '0) seq_ff <= '0;
         end
      end
   end

   assign stat.is_pop    = in_op;
   assign stat.empty     = (total_ff == '0);
   assign stat.full      = (total_ff >= TW'(CAPACITY));
   assign stat.scan_end  = (scan_ff >= last_idx);
   assign stat.clear_end = clr_done_ff || (clr_ff == '1);
   assign popped_value   = popped_ff;
   assign status         = status_ff;

   logic unused;
   assign unused = op_ff ^ (EW != $bits(entry_type));
endmodule

// File: rtl/frequency_stack.sv
// Top level of the frequency stack: controller plus datapath.
// Depends on fstk_pkg, fstk_ctrl, fstk_dp.
//
//  channel  direction  accept            payload
//  req      in         tvalid & tready   tdata item_value, tuser opcode
//  rsp      out        tvalid & tready   tdata popped_value, tuser status
//
// A push reads the count, then writes the entry; a pop runs the scan that
// reads the entry memory one slot per cycle. A dropped or empty request
// goes straight to the response. After reset a clear pass zeroes the
// count memory while req_tready is low. The response holds until taken.
module frequency_stack #(
   parameter int unsigned CAPACITY   = fstk_pkg::DefCapacity,
   parameter int unsigned VALUE_BITS = fstk_pkg::DefValueBits,
   parameter int unsigned SEQ_BITS   = fstk_pkg::DefSeqBits
) (
   input  logic clock,
   input  logic reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [((VALUE_BITS+7)/8)*8-1:0] req_tdata, // item_value
   input  logic                  req_tuser,           // opcode
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [((VALUE_BITS+7)/8)*8-1:0] rsp_tdata, // popped_value
   output logic [1:0]            rsp_tuser            // status
);
   import fstk_pkg::*;

   localparam int unsigned DW = ((VALUE_BITS + 7) / 8) * 8;

   cmd_type               cmd;
   stat_type              stat;
   logic                  idle;
   logic [VALUE_BITS-1:0] popped_value;
   status_type            status;

   assign req_tready = idle;

   fstk_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(req_tvalid), .taken(rsp_tready),
      .stat(stat), .cmd(cmd), .idle(idle), .out_valid(rsp_tvalid)
   );

   fstk_dp #(.CAPACITY(CAPACITY), .VALUE_BITS(VALUE_BITS), .SEQ_BITS(SEQ_BITS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .in_op(req_tuser),
      .in_value(req_tdata[VALUE_BITS-1:0]), .stat(stat),
      .popped_value(popped_value), .status(status)
   );

   assign rsp_tdata = DW'(popped_value);
   assign rsp_tuser = status;
endmodule

// File: rtl/fstk_check.sv
// Port-level checks for the frequency stack.
// Binds to frequency_stack; depends on fstk_pkg.
module fstk_check #(
   parameter int unsigned VALUE_BITS = fstk_pkg::DefValueBits
) (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [((VALUE_BITS+7)/8)*8-1:0] rsp_tdata,
   input logic [1:0] rsp_tuser
);
   import fstk_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response dropped");
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid) else $error("request taken while busy");
   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready) else $error("ready stayed high");
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_POPPED |-> rsp_tdata == '0)
      else $error("nonzero value without pop");
endmodule

bind frequency_stack fstk_check #(.VALUE_BITS(VALUE_BITS)) u_check (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
   .rsp_tuser(rsp_tuser)
);

// File: tb/testbench.sv
// Self-checking testbench for frequency_stack: directed table, capacity fill and drain, then random push/pop traffic.
// Depends on fstk_pkg and the frequency_stack RTL; predicts each response locally.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import fstk_pkg::*;

   localparam int Cap = 64;
   localparam int StallLimit = 20000;

   typedef struct {
      logic       op;
      logic [7:0] val;
      logic       known;
      logic [7:0] exp_val;
      status_type exp_st;
   } row_type;

   typedef struct {
      logic [7:0] val;
      status_type st;
   } resp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [7:0] req_tdata = '0;    // item_value
   logic req_tuser = 1'b0;        // opcode
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;         // popped_value
   logic [1:0] rsp_tuser;         // status

   frequency_stack u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always #2 clock = ~clock;

   // predictor state
   logic [6:0]  stk_count [Cap];
   logic [7:0]  stk_value [Cap];
   logic [31:0] stk_seq [Cap];
   int          stk_total;
   logic [6:0]  freq [256];
   logic [31:0] next_seq;

   resp_type pending_rsp[$];
   int    errors = 0;
   int    idle_cycles = 0;
   bit    stim_done = 0;

   task automatic report(input string msg);
      $display("mismatch: %s", msg);
      errors++;
   endtask

   function automatic resp_type predict_stack(input logic op, input logic [7:0] val);
      resp_type r;
      int best;
      r.val = 8'h00;
      if (op == OP_PUSH) begin
         if (stk_total >= Cap) begin
            r.st = ST_FULL;
         end else begin
            freq[val]++;
            stk_count[stk_total] = freq[val];
            stk_value[stk_total] = val;
            stk_seq[stk_total] = next_seq;
            stk_total++;
            next_seq++;
            r.st = ST_PUSHED;
         end
      end else if (stk_total == 0) begin
         r.st = ST_EMPTY;
      end else begin
         best = 0;
         for (int i = 1; i < stk_total; i++)
            if (stk_count[i] > stk_count[best] ||
                (stk_count[i] == stk_count[best] && stk_seq[i] > stk_seq[best]))
               best = i;
         r.val = stk_value[best];
         if (freq[r.val] > 0) freq[r.val]--;
         stk_total--;
         stk_count[best] = stk_count[stk_total];
         stk_value[best] = stk_value[stk_total];
         stk_seq[best] = stk_seq[stk_total];
         if (stk_total == 0) next_seq = 0;
         r.st = ST_POPPED;
      end
      return r;
   endfunction

   task automatic send_request(input row_type row);
      resp_type r;
      int gap;
      if ($urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 6);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= row.val;
      req_tuser <= row.op;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      r = predict_stack(row.op, row.val);
      if (row.known && (r.val !== row.exp_val || r.st !== row.exp_st))
         report($sformatf("table row disagrees with prediction op=%0d", row.op));
      pending_rsp.push_back(r);
   endtask

   // receiver: stall pattern
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(0, 9) < 7) || (($urandom % 64) < 8);
   end

   always @(posedge clock) begin
      resp_type e;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= StallLimit) begin
            $display("[frequency_stack] ERROR");
            $finish;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_rsp.size() == 0) begin
               report("response with nothing expected");
            end else begin
               e = pending_rsp.pop_front();
               if (rsp_tdata !== e.val)
                  report($sformatf("popped_value %0h want %0h", rsp_tdata, e.val));
               if (rsp_tuser !== e.st)
                  report($sformatf("status %0d want %0d", rsp_tuser, e.st));
            end
         end
      end
   end

   function automatic row_type mk(input logic op, input logic [7:0] v, input logic k,
                                  input logic [7:0] ev, input status_type es);
      row_type r;
      r.op = op; r.val = v; r.known = k; r.exp_val = ev; r.exp_st = es;
      return r;
   endfunction

   initial begin
      row_type dir_rows[$];
      row_type row;
      int depth;
      int burst;
      stk_total = 0;
      next_seq = 0;
      foreach (freq[i]) freq[i] = 7'd0;

      dir_rows.push_back(mk(OP_POP,  8'h00, 1'b1, 8'h00, ST_EMPTY));
      dir_rows.push_back(mk(OP_PUSH, 8'h00, 1'b1, 8'h00, ST_PUSHED));
      dir_rows.push_back(mk(OP_PUSH, 8'hFF, 1'b1, 8'h00, ST_PUSHED));
      dir_rows.push_back(mk(OP_PUSH, 8'h00, 1'b1, 8'h00, ST_PUSHED));
      dir_rows.push_back(mk(OP_PUSH, 8'hFF, 1'b1, 8'h00, ST_PUSHED));
      dir_rows.push_back(mk(OP_PUSH, 8'hA5, 1'b1, 8'h00, ST_PUSHED));
      dir_rows.push_back(mk(OP_POP,  8'h5A, 1'b1, 8'hFF, ST_POPPED));
      dir_rows.push_back(mk(OP_POP,  8'h00, 1'b1, 8'h00, ST_POPPED));
      dir_rows.push_back(mk(OP_POP,  8'h00, 1'b0, 8'h00, ST_POPPED));
      dir_rows.push_back(mk(OP_POP,  8'h00, 1'b0, 8'h00, ST_POPPED));
      dir_rows.push_back(mk(OP_POP,  8'h00, 1'b0, 8'h00, ST_POPPED));
      dir_rows.push_back(mk(OP_POP,  8'hFF, 1'b1, 8'h00, ST_EMPTY));

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) send_request(dir_rows[i]);

      // fill to capacity, then overflow, then drain to empty
      for (int i = 0; i < Cap; i++)
         send_request(mk(OP_PUSH, 8'($urandom_range(0, 7)), 1'b0, 8'h00, ST_PUSHED));
      send_request(mk(OP_PUSH, 8'h81, 1'b1, 8'h00, ST_FULL));
      send_request(mk(OP_PUSH, 8'h7E, 1'b1, 8'h00, ST_FULL));
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      for (int i = 0; i < Cap; i++)
         send_request(mk(OP_POP, 8'($urandom), 1'b0, 8'h00, ST_POPPED));
      send_request(mk(OP_POP, 8'h00, 1'b1, 8'h00, ST_EMPTY));

      // random traffic in bursts, biased by stack depth
      for (int n = 0; n < 260; ) begin
         burst = $urandom_range(1, 20);
         for (int b = 0; b < burst && n < 260; b++, n++) begin
            depth = stk_total;
            row.known = 1'b0; row.exp_val = 8'h00; row.exp_st = ST_PUSHED;
            if (depth == 0) row.op = ($urandom_range(0, 5) == 0) ? OP_POP : OP_PUSH;
            else if (depth >= Cap - 2) row.op = ($urandom_range(0, 3) == 0) ? OP_PUSH : OP_POP;
            else row.op = ($urandom_range(0, 9) < 6) ? OP_PUSH : OP_POP;
            row.val = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5));
            send_request(row);
         end
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         if (n > 200 && n < 220) while (pending_rsp.size() != 0) @(posedge clock);
      end
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (errors == 0) $display("[frequency_stack] OK");
      else $display("[frequency_stack] ERROR");
      $finish;
   end
endmodule

// File: frequency_stack.f
rtl/fstk_pkg.sv
rtl/fstk_ctrl.sv
rtl/fstk_dp.sv
rtl/frequency_stack.sv
rtl/fstk_check.sv
tb/testbench.sv
